// ===== rtl/fbe_pkg.sv =====
// Shared types and constants of the filename byte escaper.
`default_nettype none

package fbe_pkg;

  // Display modes held in the configuration register.
  typedef enum logic [1:0] {
    QM_RAW      = 2'd0,
    QM_QUESTION = 2'd1,
    QM_OCTAL    = 2'd2,
    QM_CESC     = 2'd3
  } quoting_mode_e;

  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] PRINT_LOW    = 8'h20;
  localparam logic [7:0] PRINT_HIGH   = 8'h7E;

  // Bytes of one display run, at most four of them.
  localparam int unsigned RUN_BYTES   = 4;
  localparam int unsigned RUN_IDX_W   = $clog2(RUN_BYTES);

  // Depth of the queue between classification and emission.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One input transaction.
  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_end;
  } name_item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_name_end;
  } disp_item_t;

  // A classified input byte: its display bytes, run length minus one and end mark.
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic [RUN_IDX_W-1:0]      len_m1;
    logic                      name_end;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/filename_byte_escaper.sv =====
// Top level of the filename byte escaper: front end, run queue and back end.
// The first display byte of a transaction passes through the run queue and the back end's
// result register, behind any runs already queued. The back end sends one display byte per
// cycle while the queue holds a run; an input byte gives one, two or four display bytes (four
// for an octal escape), so sustained rate is set by the back end's byte counter.
// The receiver cannot stall; a new transaction is taken whenever the two-entry queue has room.
// Reset empties the queue and the result register and sets the mode to question marks.
`default_nettype none

module filename_byte_escaper (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Configuration write channel for the quoting mode.
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_data_i,
  // Command channel: a transaction is accepted when start is high and busy is low.
  input  wire                  start,
  output logic                 busy,
  input  fbe_pkg::name_item_t  cmd_i,
  // Result channel: each display byte is valid for exactly one cycle.
  output logic                 res_valid_o,
  output fbe_pkg::disp_item_t  res_o
);

  // The front end classifies each accepted byte into a complete run of display bytes,
  // so the mode only matters at acceptance time.
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  fbe_pkg::run_t run_in;
  fbe_pkg::run_t run_head;

  fbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .cmd_i        (cmd_i),
    .queue_full_i (q_full),
    .busy         (busy),
    .push_o       (push),
    .run_o        (run_in)
  );

  // The queue decouples acceptance from emission, so a short run can be taken
  // while the back end is still spelling out a long escape.
  fbe_run_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run_in),
    .pop_i   (pop),
    .head_o  (run_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The back end walks the head run one byte per cycle and retires it on its last byte.
  fbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (run_head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

`ifndef ASSERT_OFF
  // The end-of-name mark only ever rides on the last byte of a run.
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_name_end |-> res_o.run_last)
    else $error("name end flagged on a byte that is not the last of its run");

  // With nothing queued, the result register must not produce a byte.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |=> !res_valid_o)
    else $error("result emitted while the run queue was empty");

  // A transaction accepted into an empty queue shows its first byte once the result register takes it.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && q_empty |-> ##2 res_valid_o)
    else $error("first display byte did not appear two cycles after acceptance");

  // Busy is only raised while the queue holds a run.
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_empty)
    else $error("busy raised while the run queue was empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/fbe_front.sv =====
// Front end: quoting mode register, input handshake and byte classification.
`default_nettype none

module fbe_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [1:0]               cfg_data_i,
  input  wire                      start,
  input  fbe_pkg::name_item_t      cmd_i,
  input  wire                      queue_full_i,
  output logic                     busy,
  output logic                     push_o,
  output fbe_pkg::run_t            run_o
);

  fbe_pkg::quoting_mode_e mode_q;
  logic [7:0]             b;
  logic                   printable;
  logic                   has_c;
  logic [7:0]             c_letter;
  logic [7:0]             oct2, oct1, oct0;

  assign cfg_ready_o = 1'b1;
  assign busy        = queue_full_i;
  assign push_o      = start && !queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fbe_pkg::QM_QUESTION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= fbe_pkg::quoting_mode_e'(cfg_data_i);
    end
  end

  assign b         = cmd_i.name_byte;
  assign printable = (b >= fbe_pkg::PRINT_LOW) && (b <= fbe_pkg::PRINT_HIGH);
  assign oct2      = {5'b00110, 1'b0, b[7:6]};
  assign oct1      = {5'b00110, b[5:3]};
  assign oct0      = {5'b00110, b[2:0]};

  // Letters of the two-byte C escapes.
  always_comb begin
    has_c    = 1'b1;
    c_letter = 8'h00;
    unique case (b)
      8'h00:   c_letter = 8'h30;
      8'h0D:   c_letter = 8'h72;
      8'h0A:   c_letter = 8'h6E;
      8'h0B:   c_letter = 8'h76;
      8'h07:   c_letter = 8'h61;
      8'h08:   c_letter = 8'h62;
      8'h0C:   c_letter = 8'h66;
      8'h09:   c_letter = 8'h74;
      8'h22:   c_letter = 8'h22;
      8'h5C:   c_letter = 8'h5C;
      default: has_c    = 1'b0;
    endcase
  end

  always_comb begin
    run_o          = '0;
    run_o.name_end = cmd_i.name_end;
    unique case (mode_q) inside
      fbe_pkg::QM_RAW: begin
        run_o.bytes[0] = b;
      end
      fbe_pkg::QM_QUESTION: begin
        run_o.bytes[0] = printable ? b : fbe_pkg::CH_QUESTION;
      end
      fbe_pkg::QM_OCTAL, fbe_pkg::QM_CESC: begin
        if (printable && !has_c) begin
          run_o.bytes[0] = b;
        end else if ((mode_q == fbe_pkg::QM_CESC) && has_c) begin
          run_o.bytes[0] = fbe_pkg::CH_BACKSLASH;
          run_o.bytes[1] = c_letter;
          run_o.len_m1   = fbe_pkg::RUN_IDX_W'(1);
        end else begin
          run_o.bytes[0] = fbe_pkg::CH_BACKSLASH;
          run_o.bytes[1] = oct2;
          run_o.bytes[2] = oct1;
          run_o.bytes[3] = oct0;
          run_o.len_m1   = fbe_pkg::RUN_IDX_W'(fbe_pkg::RUN_BYTES - 1);
        end
      end
      default: begin
        run_o.bytes[0] = b;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fbe_run_queue.sv =====
// Short queue of classified runs between the front and back ends.
`default_nettype none

module fbe_run_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  fbe_pkg::run_t        run_i,
  input  wire                  pop_i,
  output fbe_pkg::run_t        head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  fbe_pkg::run_t                     mem_q [fbe_pkg::QUEUE_DEPTH];
  logic [fbe_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [fbe_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [fbe_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == fbe_pkg::QCNT_W'(fbe_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == fbe_pkg::QPTR_W'(fbe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fbe_pkg::QPTR_W'(fbe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbe_back.sv =====
// Back end: emits the bytes of the head run one per cycle into the result register.
`default_nettype none

module fbe_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  fbe_pkg::run_t        head_i,
  input  wire                  head_valid_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  output fbe_pkg::disp_item_t  res_o
);

  logic [fbe_pkg::RUN_IDX_W-1:0] idx_q, idx_d;
  logic                          res_valid_q;
  fbe_pkg::disp_item_t           res_q, res_d;
  logic                          at_last;

  assign at_last = (idx_q == head_i.len_m1);
  assign pop_o   = head_valid_i && at_last;

  always_comb begin
    idx_d              = idx_q;
    res_d.out_byte     = head_i.bytes[idx_q];
    res_d.run_last     = at_last;
    res_d.out_name_end = at_last && head_i.name_end;
    if (head_valid_i) begin
      idx_d = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      res_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the filename byte escaper: directed table, then random names.
`default_nettype none

module testbench;

  // The first display byte of a transaction passes the run queue and the result register;
  // the bench waits on after the last expected byte to see the block idle.
  localparam int unsigned SETTLE_CYCLES = 6;
  // The slowest legal run is at most 385 transactions of four display bytes each, plus long
  // sender gaps and a handful of drains. This limit is many times that.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 36;

  // The display run of one name byte: b[k] is the k-th byte sent out, n the byte count.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } disp_run_t;

  // Per transaction: either a display run typed in by hand, or a request to predict one.
  typedef struct packed {
    logic      typed;
    disp_run_t run;
  } typed_run_t;

  // One row of the directed table.
  typedef struct packed {
    fbe_pkg::quoting_mode_e mode;
    fbe_pkg::name_item_t    item;
    logic                   typed;
    disp_run_t              run;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_data_i;
  logic                start;
  logic                busy;
  fbe_pkg::name_item_t cmd_i;
  logic                res_valid_o;
  fbe_pkg::disp_item_t res_o;

  filename_byte_escaper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Scoreboard state. The watcher below owns mode_shadow and the display queue; the
  // stimulus side only pushes entries into typed_runs and reads the queue size.
  fbe_pkg::quoting_mode_e mode_shadow;
  fbe_pkg::quoting_mode_e programmed_mode;
  fbe_pkg::disp_item_t    expected_display[$];
  typed_run_t             typed_runs[$];
  int unsigned            mismatch_count;
  int unsigned            cycle_count;
  logic                   quiet_sender;
  dir_row_t               stim_rows [DIRECTED_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit: a hung handshake or a lost display byte ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Works out the display form of one name byte under the given quoting mode.
  function automatic disp_run_t display_run(fbe_pkg::quoting_mode_e mode, logic [7:0] c);
    disp_run_t  r;
    logic       printable;
    logic [7:0] letter;
    r = '0;
    printable = (c >= fbe_pkg::PRINT_LOW) && (c <= fbe_pkg::PRINT_HIGH);
    // Second byte of the two-byte C escape; zero where the byte has none. NUL maps to
    // the digit zero, so a nonzero letter marks every byte with a short escape.
    case (c)
      8'h00:                 letter = "0";
      8'h07:                 letter = "a";
      8'h08:                 letter = "b";
      8'h09:                 letter = "t";
      8'h0A:                 letter = "n";
      8'h0B:                 letter = "v";
      8'h0C:                 letter = "f";
      8'h0D:                 letter = "r";
      8'h22:                 letter = 8'h22;
      fbe_pkg::CH_BACKSLASH: letter = fbe_pkg::CH_BACKSLASH;
      default:               letter = 8'h00;
    endcase
    case (mode)
      fbe_pkg::QM_RAW: begin
        r.b[0] = c;
        r.n    = 3'd1;
      end
      fbe_pkg::QM_QUESTION: begin
        r.b[0] = printable ? c : fbe_pkg::CH_QUESTION;
        r.n    = 3'd1;
      end
      default: begin
        // Octal and C modes share the pass-through rule: printable, but not the quote
        // and not the backslash.
        if (printable && c != 8'h22 && c != fbe_pkg::CH_BACKSLASH) begin
          r.b[0] = c;
          r.n    = 3'd1;
        end else if (mode == fbe_pkg::QM_CESC && letter != 8'h00) begin
          r.b[0] = fbe_pkg::CH_BACKSLASH;
          r.b[1] = letter;
          r.n    = 3'd2;
        end else begin
          // Always three octal digits, most significant first.
          r.b[0] = fbe_pkg::CH_BACKSLASH;
          r.b[1] = "0" | {6'd0, c[7:6]};
          r.b[2] = "0" | {5'd0, c[5:3]};
          r.b[3] = "0" | {5'd0, c[2:0]};
          r.n    = 3'd4;
        end
      end
    endcase
    return r;
  endfunction

  // Builds a directed row. A nonzero count means the run is typed in: text holds the
  // display bytes right-aligned, first byte sent on the left. A zero count leaves the
  // row to the predictor.
  function automatic dir_row_t dir_row(fbe_pkg::quoting_mode_e m, logic [7:0] c, logic e,
                                       logic [2:0] n, logic [31:0] text);
    dir_row_t r;
    r = '0;
    r.mode           = m;
    r.item.name_byte = c;
    r.item.name_end  = e;
    r.typed          = (n != 3'd0);
    r.run.n          = n;
    for (int k = 0; k < n; k++) begin
      r.run.b[k] = text[8*(n-1-k) +: 8];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Watcher: tracks the mode register, predicts each accepted transaction and checks
  // every display byte against the oldest expected one. All of it samples at the edge,
  // so it sees the values the block saw.
  always @(posedge clk_i) begin : watch
    typed_run_t          entry;
    disp_run_t           run;
    fbe_pkg::disp_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_shadow = fbe_pkg::quoting_mode_e'(cfg_data_i);
      end
      if (start && !busy) begin
        if (typed_runs.size() == 0) begin
          report_mismatch($sformatf("transaction with byte %02h accepted but never sent",
                                    cmd_i.name_byte));
        end else begin
          entry = typed_runs.pop_front();
          run   = entry.typed ? entry.run : display_run(mode_shadow, cmd_i.name_byte);
          for (int k = 0; k < run.n; k++) begin
            want.out_byte     = run.b[k];
            want.run_last     = (k == run.n - 1);
            want.out_name_end = (k == run.n - 1) && cmd_i.name_end;
            expected_display.push_back(want);
          end
        end
      end
      if (res_valid_o) begin
        if (expected_display.size() == 0) begin
          report_mismatch($sformatf("display byte %02h with nothing expected",
                                    res_o.out_byte));
        end else begin
          want = expected_display.pop_front();
          if (res_o.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte: got %02h, expected %02h",
                                      res_o.out_byte, want.out_byte));
          end
          if (res_o.run_last !== want.run_last) begin
            report_mismatch($sformatf("run_last: got %0b, expected %0b",
                                      res_o.run_last, want.run_last));
          end
          if (res_o.out_name_end !== want.out_name_end) begin
            report_mismatch($sformatf("out_name_end: got %0b, expected %0b",
                                      res_o.out_name_end, want.out_name_end));
          end
        end
      end
    end
  end

  // Mostly printable bytes and plain random ones, with a share of the bytes that each
  // mode treats specially.
  function automatic logic [7:0] pick_name_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'($urandom_range(8'h20, 8'h7E));
      4: begin
        case ($urandom_range(0, 13))
          0:       c = 8'h00;
          1:       c = 8'h07;
          2:       c = 8'h08;
          3:       c = 8'h09;
          4:       c = 8'h0A;
          5:       c = 8'h0B;
          6:       c = 8'h0C;
          7:       c = 8'h0D;
          8:       c = 8'h22;
          9:       c = fbe_pkg::CH_BACKSLASH;
          10:      c = 8'h7F;
          11:      c = 8'hFF;
          12:      c = 8'h1F;
          default: c = 8'h80;
        endcase
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Sends one transaction after a random gap. Between transactions start stays high
  // when there is no gap, so back-to-back traffic really happens. Garbage sits on the
  // command port during gaps.
  task automatic send_name_byte(fbe_pkg::name_item_t item, logic typed, disp_run_t run);
    typed_run_t  entry;
    int unsigned gap;
    entry.typed = typed;
    entry.run   = run;
    typed_runs.push_back(entry);
    gap = $urandom_range(0, 99);
    if (quiet_sender || gap < 60) begin
      gap = 0;
    end else if (gap < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      start <= 1'b0;
      cmd_i <= fbe_pkg::name_item_t'(9'($urandom_range(0, 511)));
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until every expected display byte has come out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_display.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the mode register; only called once the block is idle.
  task automatic program_mode(fbe_pkg::quoting_mode_e mode);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    programmed_mode = mode;
  endtask

  initial begin : stimulus
    fbe_pkg::name_item_t item;
    int unsigned         sent;
    int unsigned         name_len;
    logic                mid_drained;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    start           = 1'b0;
    cmd_i           = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    quiet_sender    = 1'b0;
    mid_drained     = 1'b0;
    mode_shadow     = fbe_pkg::QM_QUESTION;
    programmed_mode = fbe_pkg::QM_QUESTION;

    // Directed table. The question-mark rows run on the reset value of the mode.
    // Typed rows cover reset behavior, the extreme bytes and the short and long escapes;
    // the rest are predicted.
    stim_rows[0]  = dir_row(fbe_pkg::QM_QUESTION, 8'h41, 1'b0, 3'd1, "A");
    stim_rows[1]  = dir_row(fbe_pkg::QM_QUESTION, 8'h00, 1'b0, 3'd1, "?");
    stim_rows[2]  = dir_row(fbe_pkg::QM_QUESTION, 8'hFF, 1'b1, 3'd1, "?");
    stim_rows[3]  = dir_row(fbe_pkg::QM_QUESTION, 8'h20, 1'b0, 3'd0, 0);
    stim_rows[4]  = dir_row(fbe_pkg::QM_QUESTION, 8'h7F, 1'b1, 3'd0, 0);
    stim_rows[5]  = dir_row(fbe_pkg::QM_RAW,      8'hFF, 1'b0, 3'd1, 8'hFF);
    stim_rows[6]  = dir_row(fbe_pkg::QM_RAW,      8'h00, 1'b1, 3'd1, 8'h00);
    stim_rows[7]  = dir_row(fbe_pkg::QM_OCTAL,    8'hFF, 1'b0, 3'd4, "\\377");
    stim_rows[8]  = dir_row(fbe_pkg::QM_OCTAL,    8'h00, 1'b0, 3'd4, "\\000");
    stim_rows[9]  = dir_row(fbe_pkg::QM_OCTAL,    8'h22, 1'b0, 3'd0, 0);
    stim_rows[10] = dir_row(fbe_pkg::QM_OCTAL,    8'h5C, 1'b0, 3'd0, 0);
    stim_rows[11] = dir_row(fbe_pkg::QM_OCTAL,    8'h0A, 1'b1, 3'd0, 0);
    stim_rows[12] = dir_row(fbe_pkg::QM_CESC,     8'h00, 1'b0, 3'd2, "\\0");
    stim_rows[13] = dir_row(fbe_pkg::QM_CESC,     8'h0A, 1'b0, 3'd2, "\\n");
    stim_rows[14] = dir_row(fbe_pkg::QM_CESC,     8'h0D, 1'b0, 3'd0, 0);
    stim_rows[15] = dir_row(fbe_pkg::QM_CESC,     8'h0B, 1'b0, 3'd0, 0);
    stim_rows[16] = dir_row(fbe_pkg::QM_CESC,     8'h07, 1'b0, 3'd0, 0);
    stim_rows[17] = dir_row(fbe_pkg::QM_CESC,     8'h08, 1'b0, 3'd0, 0);
    stim_rows[18] = dir_row(fbe_pkg::QM_CESC,     8'h0C, 1'b0, 3'd0, 0);
    stim_rows[19] = dir_row(fbe_pkg::QM_CESC,     8'h09, 1'b0, 3'd0, 0);
    stim_rows[20] = dir_row(fbe_pkg::QM_CESC,     8'h22, 1'b0, 3'd0, 0);
    stim_rows[21] = dir_row(fbe_pkg::QM_CESC,     8'h5C, 1'b0, 3'd0, 0);
    stim_rows[22] = dir_row(fbe_pkg::QM_CESC,     8'hFF, 1'b0, 3'd4, "\\377");
    stim_rows[23] = dir_row(fbe_pkg::QM_CESC,     8'h1B, 1'b0, 3'd0, 0);
    stim_rows[24] = dir_row(fbe_pkg::QM_CESC,     8'h41, 1'b1, 3'd0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (stim_rows[i].mode != programmed_mode) begin
        program_mode(stim_rows[i].mode);
      end
      send_name_byte(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].run);
    end

    // Random phases. The first four visit every mode once; the rest pick a mode at
    // random. Most traffic is whole names ending in the end mark, the rest single bytes
    // with a random end mark. Some phases run with the sender never pausing.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       program_mode(fbe_pkg::QM_QUESTION);
        1:       program_mode(fbe_pkg::QM_CESC);
        2:       program_mode(fbe_pkg::QM_RAW);
        3:       program_mode(fbe_pkg::QM_OCTAL);
        default: program_mode(fbe_pkg::quoting_mode_e'($urandom_range(0, 3)));
      endcase
      quiet_sender = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Halfway through one phase the sender holds off until the block has emptied.
        if (p == 4 && !mid_drained && sent >= PHASE_ITEMS / 2) begin
          drain();
          mid_drained = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          name_len = $urandom_range(1, 10);
          for (int k = 0; k < name_len; k++) begin
            item.name_byte = pick_name_byte();
            item.name_end  = (k == name_len - 1);
            send_name_byte(item, 1'b0, '0);
          end
          sent += name_len;
        end else begin
          item.name_byte = pick_name_byte();
          item.name_end  = 1'($urandom_range(0, 1));
          send_name_byte(item, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fbe_pkg.sv
rtl/fbe_front.sv
rtl/fbe_run_queue.sv
rtl/fbe_back.sv
rtl/filename_byte_escaper.sv
tb/sv/testbench.sv
